[rtl/core/open_address_hash_table_assert.svh]
// Assertion macros used by the hash table RTL.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OAHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OAHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/oaht_pkg.sv]
// Package with the types, constants and codes of the hash table.
package oaht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 64;
  localparam int PAYLOAD_W   = 5;
  localparam int SLOT_W      = 6;
  localparam int DUP_W       = 32;
  localparam int HASH_SHIFT  = 33;
  localparam int HASH_STAGES = 5;

  localparam logic [63:0] HASH_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ZERO_KEY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESULT
  } state_t;

  typedef struct packed {
    mark_t                mark;
    logic [PAYLOAD_W-1:0] payload;
    logic [KEY_W-1:0]     key;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } mem_wr_t;

endpackage

[rtl/core/oaht_hash.sv]
// Five-stage pipelined xor-shift and multiply finalizer giving the start slot.
module oaht_hash import oaht_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output idx_t             slot
);

  logic [HASH_STAGES-1:0] vld_r;
  logic [63:0] s0_r, s1_r;
  logic [63:0] pa_r, qa_r;
  logic [31:0] pb_r, pc_r, qb_r, qc_r;
  idx_t        slot_r;
  logic [63:0] y1, y2, x2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[HASH_STAGES-2:0], go};
    end
  end

  // A 64-bit product keeps its low half: one full low product and two cross terms.
  always_comb begin
    y1 = pa_r + {pb_r + pc_r, 32'b0};
    y2 = qa_r + {qb_r + qc_r, 32'b0};
    x2 = y2 ^ (y2 >> HASH_SHIFT);
  end

  always_ff @(posedge clk) begin
    s0_r   <= key ^ (key >> HASH_SHIFT);
    pa_r   <= s0_r[31:0] * HASH_C1[31:0];
    pb_r   <= s0_r[63:32] * HASH_C1[31:0];
    pc_r   <= s0_r[31:0] * HASH_C1[63:32];
    s1_r   <= y1 ^ (y1 >> HASH_SHIFT);
    qa_r   <= s1_r[31:0] * HASH_C2[31:0];
    qb_r   <= s1_r[63:32] * HASH_C2[31:0];
    qc_r   <= s1_r[31:0] * HASH_C2[63:32];
    slot_r <= x2[IDX_W-1:0];
  end

  assign done = vld_r[HASH_STAGES-1];
  assign slot = slot_r;

endmodule

[rtl/core/oaht_store.sv]
// Slot memory with one read and one write port and per-slot valid flags.
module oaht_store import oaht_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  idx_t    rd_addr,
  input  mem_wr_t wr,
  output entry_t  rd_entry
);

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_data_r;
  logic [TABLE_DEPTH-1:0] vld_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // A slot never written since reset reads as empty.
  always_comb begin
    rd_entry      = rd_data_r;
    if (!rd_vld_r) begin
      rd_entry.mark = MARK_EMPTY;
    end
  end

endmodule

[rtl/core/oaht_ctrl.sv]
// Probe sequencer: walks the slots, decides the outcome and writes back.
`include "open_address_hash_table_assert.svh"

module oaht_ctrl import oaht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_cmd,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [PAYLOAD_W-1:0] in_payload,
  input  logic                 hash_done,
  input  idx_t                 hash_slot,
  input  entry_t               rd_entry,
  output logic                 busy,
  output logic                 hash_go,
  output idx_t                 rd_addr,
  output mem_wr_t              wr,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [DUP_W-1:0]     out_duplicate_total
);

  state_t               state_r, state_nxt;
  logic                 cmd_r, cmd_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;
  idx_t                 cur_r, cur_nxt;
  idx_t                 cnt_r, cnt_nxt;
  logic                 tomb_vld_r, tomb_vld_nxt;
  idx_t                 tomb_r, tomb_nxt;
  logic [DUP_W-1:0]     dup_r, dup_nxt;
  status_t              status_r, status_nxt;
  idx_t                 slot_r, slot_nxt;

  logic    accept;
  logic    is_empty, is_tomb, key_hit, new_tomb, last;
  idx_t    next_idx;
  logic    finish, wr_req, dup_inc;
  status_t fin_status;
  idx_t    wr_idx;
  entry_t  wr_ent;

  assign accept = start && !busy;

  always_comb begin
    is_empty = (rd_entry.mark == MARK_EMPTY);
    is_tomb  = (rd_entry.mark == MARK_TOMB);
    key_hit  = (rd_entry.mark == MARK_USED) && (rd_entry.key == key_r);
    new_tomb = is_tomb && !tomb_vld_r;
    last     = (cnt_r == IDX_W'(TABLE_DEPTH - 1));
    next_idx = (cur_r == IDX_W'(TABLE_DEPTH - 1)) ? '0 : cur_r + 1'b1;
  end

  always_comb begin
    finish     = 1'b0;
    wr_req     = 1'b0;
    dup_inc    = 1'b0;
    fin_status = ST_NOT_FOUND;
    wr_idx     = cur_r;
    wr_ent     = '{mark: MARK_USED, payload: payload_r, key: key_r};
    if (cmd_r == CMD_INSERT) begin
      if (is_empty) begin
        finish     = 1'b1;
        wr_req     = 1'b1;
        fin_status = ST_INSERTED;
        wr_idx     = tomb_vld_r ? tomb_r : cur_r;
      end else if (key_hit) begin
        finish     = 1'b1;
        dup_inc    = 1'b1;
        fin_status = ST_DUPLICATE;
      end else if (last) begin
        finish = 1'b1;
        if (tomb_vld_r || new_tomb) begin
          wr_req     = 1'b1;
          fin_status = ST_INSERTED;
          wr_idx     = tomb_vld_r ? tomb_r : cur_r;
        end else begin
          fin_status = ST_FULL;
        end
      end
    end else begin
      if (is_empty || last) begin
        finish = 1'b1;
      end
      if (key_hit) begin
        finish     = 1'b1;
        wr_req     = 1'b1;
        fin_status = ST_REMOVED;
        wr_ent     = '{mark: MARK_TOMB, payload: '0, key: '0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_key == '0) ? S_RESULT : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state_r != S_IDLE);
    hash_go   = accept && (in_key != '0);
    out_valid = (state_r == S_RESULT);
    rd_addr   = cur_r;
    unique case (state_r)
      S_HASH:  rd_addr = hash_slot;
      S_PROBE: rd_addr = next_idx;
      S_IDLE, S_RESULT: rd_addr = cur_r;
    endcase
    wr.en   = (state_r == S_PROBE) && wr_req;
    wr.addr = wr_idx;
    wr.data = wr_ent;
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    payload_nxt  = payload_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    tomb_vld_nxt = tomb_vld_r;
    tomb_nxt     = tomb_r;
    dup_nxt      = dup_r;
    status_nxt   = status_r;
    slot_nxt     = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_key;
          payload_nxt = in_payload;
          status_nxt  = ST_ZERO_KEY;
          slot_nxt    = '0;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          cur_nxt      = hash_slot;
          cnt_nxt      = '0;
          tomb_vld_nxt = 1'b0;
        end
      end
      S_PROBE: begin
        if (finish) begin
          status_nxt = fin_status;
          slot_nxt   = wr_req ? wr_idx : '0;
          dup_nxt    = dup_r + DUP_W'(dup_inc);
        end else begin
          cur_nxt = next_idx;
          cnt_nxt = cnt_r + 1'b1;
          if (new_tomb) begin
            tomb_vld_nxt = 1'b1;
            tomb_nxt     = cur_r;
          end
        end
      end
      S_RESULT: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dup_r      <= '0;
      tomb_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dup_r      <= dup_nxt;
      tomb_vld_r <= tomb_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
    cur_r     <= cur_nxt;
    cnt_r     <= cnt_nxt;
    tomb_r    <= tomb_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
  end

  assign out_status          = status_r;
  assign out_slot            = SLOT_W'(slot_r);
  assign out_duplicate_total = dup_r;

  `OAHT_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `OAHT_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy, "accepted item left block idle")
  `OAHT_ASSERT_IMP(a_hash_in_wait, clk, rst_n, hash_done, state_r == S_HASH,
                   "hash finished outside the wait state")
  `OAHT_ASSERT_IMP(a_slot_zero, clk, rst_n,
                   out_valid && (status_r != ST_INSERTED) && (status_r != ST_REMOVED),
                   out_slot == '0, "slot reported without a write")

endmodule

[rtl/core/open_address_hash_table.sv]
// Top level of the linear-probing hash table with tombstones.
//
//   channel  handshake           payload
//   in       start, busy         in_cmd, in_key, in_payload
//   out      out_valid (strobe)  out_status, out_slot, out_duplicate_total
//
// An item with a zero key skips the hash and the probe and goes to the result.
// Any other item passes through the pipelined hash, a read of the home slot,
// one read per slot probed (1 to 64 slots) through the slot memory read port,
// and the result. The block takes no new item until the result is given.
// Reset clears all slots to empty at once through per-slot valid flags.
// The result strobe lasts one cycle; the receiver cannot stall it.
module open_address_hash_table import oaht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [PAYLOAD_W-1:0] in_payload,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [DUP_W-1:0]     out_duplicate_total
);

  logic    hash_go, hash_done;
  idx_t    hash_slot, rd_addr;
  mem_wr_t wr;
  entry_t  rd_entry;

  oaht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (hash_go),
    .key   (in_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  oaht_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  oaht_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_cmd              (in_cmd),
    .in_key              (in_key),
    .in_payload          (in_payload),
    .hash_done           (hash_done),
    .hash_slot           (hash_slot),
    .rd_entry            (rd_entry),
    .busy                (busy),
    .hash_go             (hash_go),
    .rd_addr             (rd_addr),
    .wr                  (wr),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_slot            (out_slot),
    .out_duplicate_total (out_duplicate_total)
  );

endmodule
